### rtl/core/rsp_pkg.sv
// ============================================================================
// rsp_pkg: shared types, widths and saturating helpers
// Q48.16 word type and the clamp-to-range add and subtract used throughout
// the ray to segment proximity pipeline.
// ============================================================================
package rsp_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned AxisW   = CoordW + 1;
  localparam int unsigned FracW   = 16;
  localparam int unsigned RadiusW = 31;
  localparam int unsigned ParamW  = 31;
  localparam int unsigned SParamW = FracW + 1;
  localparam int unsigned TQBits  = 63;
  localparam int unsigned SQBits  = FracW + 1;
  localparam int unsigned FmulLat = 3;
  localparam int unsigned Dot3Lat = FmulLat + 2;

  typedef logic signed [WordW-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordW-1){1'b0}}};

  // clamp a 65-bit exact result back into the word range
  function automatic word_t sat65(input logic signed [WordW:0] x);
    word_t r;
    if (x[WordW] != x[WordW-1]) begin
      r = x[WordW] ? WordMin : WordMax;
    end else begin
      r = x[WordW-1:0];
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    return sat65(s);
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} - {b[WordW-1], b};
    return sat65(s);
  endfunction

  // magnitude of a signed word; the most negative value maps to 2^63
  function automatic logic [WordW-1:0] mag(input word_t a);
    logic [WordW-1:0] m;
    m = a[WordW-1] ? (~a + 1'b1) : a;
    return m;
  endfunction

endpackage

### rtl/core/ray_segment_proximity_test.sv
// ============================================================================
// ray_segment_proximity_test: ray to axis segment pick test, Q16.16
// Closest points between a ray and a segment, clamped, squared gap compared
// against the squared click radius.
// ============================================================================
// Usage:
//   s_axis carries one ray/segment pair per word (twelve signed Q16.16
//   coordinates). m_axis returns one result word per pair: hit flag and the
//   ray parameter (zero when there is no hit). cfg_* writes the click radius
//   (unsigned Q15.16); write it only while no pair is in flight.
// Depth: set mostly by the restoring divider for the ray parameter, plus
//   four multiply layers of three stages each.
// Throughput: one pair per cycle while the skid register is empty; every stage
//   is a register stage and the whole pipeline advances together.
// Reset: all valid bits clear, the click radius returns to 1.0.
// Stall: the output register is backed by a skid register. When the receiver
//   stalls with both full, s_axis_tready drops and the pipeline holds; no
//   word is lost or repeated.
// ============================================================================
module ray_segment_proximity_test (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rsp_pkg::RadiusW-1:0] cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] ray_origin_x, [63:32] ray_origin_y, [95:64] ray_origin_z,
  // [127:96] ray_dir_x, [159:128] ray_dir_y, [191:160] ray_dir_z,
  // [223:192] seg_start_x, [255:224] seg_start_y, [287:256] seg_start_z,
  // [319:288] seg_end_x, [351:320] seg_end_y, [383:352] seg_end_z
  input  logic [383:0]                s_axis_tdata,
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] hit, [31:1] ray_param
  output logic [31:0]                 m_axis_tdata
);

  localparam int unsigned CW = rsp_pkg::CoordW;
  localparam int unsigned AW = rsp_pkg::AxisW;
  localparam int unsigned WW = rsp_pkg::WordW;

  // stage numbers, counted in register stages from acceptance
  localparam int unsigned KDot1  = 1 + rsp_pkg::Dot3Lat;
  localparam int unsigned KMul2  = KDot1 + rsp_pkg::FmulLat;
  localparam int unsigned KSub   = KMul2 + 1;
  localparam int unsigned KDivT  = KSub + rsp_pkg::TQBits + 1;
  localparam int unsigned KDivS  = KSub + rsp_pkg::SQBits + 1;
  localparam int unsigned KClamp = KDivT + 1;
  localparam int unsigned KMul3  = KClamp + rsp_pkg::FmulLat;
  localparam int unsigned KGap   = KMul3 + 2;
  localparam int unsigned KDist  = KGap + rsp_pkg::Dot3Lat;

  localparam logic [rsp_pkg::SParamW-1:0] SOne = rsp_pkg::SParamW'(1 << rsp_pkg::FracW);
  localparam logic [rsp_pkg::RadiusW-1:0] RadiusReset =
    rsp_pkg::RadiusW'(1 << rsp_pkg::FracW);
  localparam int unsigned ThrW = 2 * rsp_pkg::RadiusW - rsp_pkg::FracW;

  logic adv;

  // --------------------------------------------------------------------------
  // config register and squared radius
  // --------------------------------------------------------------------------
  logic [rsp_pkg::RadiusW-1:0]   radius_q;
  logic [2*rsp_pkg::RadiusW-1:0] rad2;
  logic [ThrW-1:0]               thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  assign rad2 = radius_q * radius_q;

  always_ff @(posedge clk_i) begin
    thr_q <= rad2[2*rsp_pkg::RadiusW-1:rsp_pkg::FracW];
  end

  // --------------------------------------------------------------------------
  // stage 1: unpack, segment axis and origin offset
  // --------------------------------------------------------------------------
  logic [2:0][CW-1:0] org_q, dir_q, st_q;
  logic [2:0][AW-1:0] ax_q, w_q;

  assign s_axis_tready = adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= s_axis_tdata[CW*i +: CW];
        dir_q[i] <= s_axis_tdata[CW*(3+i) +: CW];
        st_q[i]  <= s_axis_tdata[CW*(6+i) +: CW];
        ax_q[i]  <= {s_axis_tdata[CW*(9+i)+CW-1], s_axis_tdata[CW*(9+i) +: CW]}
                  - {s_axis_tdata[CW*(6+i)+CW-1], s_axis_tdata[CW*(6+i) +: CW]};
        w_q[i]   <= {s_axis_tdata[CW*i+CW-1], s_axis_tdata[CW*i +: CW]}
                  - {s_axis_tdata[CW*(6+i)+CW-1], s_axis_tdata[CW*(6+i) +: CW]};
      end
    end
  end

  logic vld_dist;

  rsp_delay #(.W(1), .N(KDist)) u_vld (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    (s_axis_tvalid),
    .q_o    (vld_dist)
  );

  // --------------------------------------------------------------------------
  // first dot products
  // --------------------------------------------------------------------------
  rsp_pkg::word_t [2:0] dir_w, ax_w, w_w;
  rsp_pkg::word_t       dd, du, uu, dw, uw;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_w[i] = {{(WW-CW){dir_q[i][CW-1]}}, dir_q[i]};
      ax_w[i]  = {{(WW-AW){ax_q[i][AW-1]}}, ax_q[i]};
      w_w[i]   = {{(WW-AW){w_q[i][AW-1]}}, w_q[i]};
    end
  end

  rsp_dot3 u_dd (.clk_i(clk_i), .en_i(adv), .a_i(dir_w), .b_i(dir_w), .dot_o(dd));
  rsp_dot3 u_du (.clk_i(clk_i), .en_i(adv), .a_i(dir_w), .b_i(ax_w),  .dot_o(du));
  rsp_dot3 u_uu (.clk_i(clk_i), .en_i(adv), .a_i(ax_w),  .b_i(ax_w),  .dot_o(uu));
  rsp_dot3 u_dw (.clk_i(clk_i), .en_i(adv), .a_i(dir_w), .b_i(w_w),   .dot_o(dw));
  rsp_dot3 u_uw (.clk_i(clk_i), .en_i(adv), .a_i(ax_w),  .b_i(w_w),   .dot_o(uw));

  // --------------------------------------------------------------------------
  // cross products for denominator and numerators
  // --------------------------------------------------------------------------
  rsp_pkg::word_t m_dduu, m_dudu, m_duuw, m_uudw, m_dduw, m_dudw;

  rsp_fmul u_dduu (.clk_i(clk_i), .en_i(adv), .a_i(dd), .b_i(uu), .p_o(m_dduu));
  rsp_fmul u_dudu (.clk_i(clk_i), .en_i(adv), .a_i(du), .b_i(du), .p_o(m_dudu));
  rsp_fmul u_duuw (.clk_i(clk_i), .en_i(adv), .a_i(du), .b_i(uw), .p_o(m_duuw));
  rsp_fmul u_uudw (.clk_i(clk_i), .en_i(adv), .a_i(uu), .b_i(dw), .p_o(m_uudw));
  rsp_fmul u_dduw (.clk_i(clk_i), .en_i(adv), .a_i(dd), .b_i(uw), .p_o(m_dduw));
  rsp_fmul u_dudw (.clk_i(clk_i), .en_i(adv), .a_i(du), .b_i(dw), .p_o(m_dudw));

  rsp_pkg::word_t den_q, nt_q, ns_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q <= rsp_pkg::sat_sub(m_dduu, m_dudu);
      nt_q  <= rsp_pkg::sat_sub(m_duuw, m_uudw);
      ns_q  <= rsp_pkg::sat_sub(m_dduw, m_dudw);
    end
  end

  rsp_pkg::word_t uw_sub, uu_sub;

  rsp_delay #(.W(2*WW), .N(KSub - KDot1)) u_uwuu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    ({uw, uu}),
    .q_o    ({uw_sub, uu_sub})
  );

  // --------------------------------------------------------------------------
  // case select and dividers
  // --------------------------------------------------------------------------
  logic           gen, upos;
  rsp_pkg::word_t t_den, s_num, s_den;
  localparam rsp_pkg::word_t WordOne = rsp_pkg::word_t'(1);

  // general case when den > 0; otherwise project onto the segment
  assign gen   = !den_q[WW-1] && (den_q != '0);
  assign upos  = !uu_sub[WW-1] && (uu_sub != '0);
  assign t_den = gen ? den_q : WordOne;
  assign s_num = gen ? ns_q : uw_sub;
  assign s_den = gen ? den_q : (upos ? uu_sub : WordOne);

  logic                       t_neg, t_ovf;
  logic [rsp_pkg::TQBits-1:0] t_qt;
  logic                       s_neg_e, s_ovf_e;
  logic [rsp_pkg::SQBits-1:0] s_qt_e;
  logic                       s_neg, s_ovf;
  logic [rsp_pkg::SQBits-1:0] s_qt;
  logic                       gen_dv, upos_dv;

  rsp_div #(.QB(rsp_pkg::TQBits)) u_div_t (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nt_q),
    .den_i (t_den),
    .neg_o (t_neg),
    .ovf_o (t_ovf),
    .q_o   (t_qt)
  );

  rsp_div #(.QB(rsp_pkg::SQBits)) u_div_s (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s_num),
    .den_i (s_den),
    .neg_o (s_neg_e),
    .ovf_o (s_ovf_e),
    .q_o   (s_qt_e)
  );

  rsp_delay #(.W(rsp_pkg::SQBits + 2), .N(KDivT - KDivS)) u_s_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    ({s_neg_e, s_ovf_e, s_qt_e}),
    .q_o    ({s_neg, s_ovf, s_qt})
  );

  rsp_delay #(.W(2), .N(KDivT - KSub)) u_flags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    ({gen, upos}),
    .q_o    ({gen_dv, upos_dv})
  );

  // --------------------------------------------------------------------------
  // clamp t >= 0 and s to [0, 1]
  // --------------------------------------------------------------------------
  logic [rsp_pkg::TQBits-1:0]  t_q;
  logic [rsp_pkg::SParamW-1:0] s_q;
  logic [rsp_pkg::ParamW-1:0]  t_out, t_out_dist;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!gen_dv || t_neg) begin
        t_q <= '0;
      end else if (t_ovf) begin
        t_q <= '1;
      end else begin
        t_q <= t_qt;
      end
      if ((!gen_dv && !upos_dv) || s_neg) begin
        s_q <= '0;
      end else if (s_ovf || (s_qt > SOne)) begin
        s_q <= SOne;
      end else begin
        s_q <= s_qt;
      end
    end
  end

  // reported parameter saturates at the field's top value
  assign t_out = (|t_q[rsp_pkg::TQBits-1:rsp_pkg::ParamW]) ? '1 : t_q[rsp_pkg::ParamW-1:0];

  rsp_delay #(.W(rsp_pkg::ParamW), .N(KDist - KClamp)) u_t_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    (t_out),
    .q_o    (t_out_dist)
  );

  // --------------------------------------------------------------------------
  // closest points and gap
  // --------------------------------------------------------------------------
  logic [2:0][CW-1:0] dir_cl, org_m3, st_m3;
  logic [2:0][AW-1:0] ax_cl;

  rsp_delay #(.W(3*(CW+AW)), .N(KClamp - 1)) u_dirax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    ({dir_q, ax_q}),
    .q_o    ({dir_cl, ax_cl})
  );

  rsp_delay #(.W(6*CW), .N(KMul3 - 1)) u_orgst (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    ({org_q, st_q}),
    .q_o    ({org_m3, st_m3})
  );

  rsp_pkg::word_t       t_w, s_w;
  rsp_pkg::word_t [2:0] mr, ms, pr_q, pa_q, gap_q;

  assign t_w = {1'b0, t_q};
  assign s_w = {{(WW-rsp_pkg::SParamW){1'b0}}, s_q};

  for (genvar i = 0; i < 3; i++) begin : g_pt
    rsp_fmul u_mr (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   ({{(WW-CW){dir_cl[i][CW-1]}}, dir_cl[i]}),
      .b_i   (t_w),
      .p_o   (mr[i])
    );
    rsp_fmul u_ms (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   ({{(WW-AW){ax_cl[i][AW-1]}}, ax_cl[i]}),
      .b_i   (s_w),
      .p_o   (ms[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pr_q[i]  <= rsp_pkg::sat_add({{(WW-CW){org_m3[i][CW-1]}}, org_m3[i]}, mr[i]);
        pa_q[i]  <= rsp_pkg::sat_add({{(WW-CW){st_m3[i][CW-1]}}, st_m3[i]}, ms[i]);
        gap_q[i] <= rsp_pkg::sat_sub(pr_q[i], pa_q[i]);
      end
    end
  end

  rsp_pkg::word_t dist2;

  rsp_dot3 u_dist (.clk_i(clk_i), .en_i(adv), .a_i(gap_q), .b_i(gap_q), .dot_o(dist2));

  // --------------------------------------------------------------------------
  // hit decision and output buffer
  // --------------------------------------------------------------------------
  logic        hit;
  logic [31:0] res;
  logic        out_v_q, skid_v_q;
  logic [31:0] out_q, skid_q;

  assign hit = dist2 < rsp_pkg::word_t'({{(WW-ThrW){1'b0}}, thr_q});
  assign res = {hit ? t_out_dist : {rsp_pkg::ParamW{1'b0}}, hit};
  assign adv = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q  <= skid_v_q || vld_dist;
      skid_v_q <= 1'b0;
    end else if (adv && vld_dist) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (adv && vld_dist) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

### rtl/core/rsp_delay.sv
// ============================================================================
// rsp_delay: enabled delay line
// Shifts a word through a fixed number of registers whenever the pipeline
// advances; used for valid bits and for operands carried alongside.
// ============================================================================
module rsp_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  // shift line, cleared at reset so valid bits start empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) sr_q[i] <= '0;
    end else if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

### rtl/core/rsp_fmul.sv
// ============================================================================
// rsp_fmul: pipelined saturating Q48.16 multiply
// Sign-magnitude 64x64 product from four 32x32 partial products, summed,
// shifted right by 16 with truncation toward zero and clamped.
// ============================================================================
module rsp_fmul (
  input  logic           clk_i,
  input  logic           en_i,
  input  rsp_pkg::word_t a_i,
  input  rsp_pkg::word_t b_i,
  output rsp_pkg::word_t p_o
);

  localparam int unsigned HalfW = rsp_pkg::WordW / 2;
  localparam int unsigned ProdW = 2 * rsp_pkg::WordW;
  localparam int unsigned TopW  = rsp_pkg::WordW + rsp_pkg::FracW;

  logic [rsp_pkg::WordW-1:0] ma, mb;
  logic [rsp_pkg::WordW-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic                      neg1_q, neg2_q;
  logic [ProdW-1:0]          sum_q;
  logic [rsp_pkg::WordW-1:0] m;
  logic                      big;
  rsp_pkg::word_t            p_q;

  assign ma = rsp_pkg::mag(a_i);
  assign mb = rsp_pkg::mag(b_i);

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[rsp_pkg::WordW-1] ^ b_i[rsp_pkg::WordW-1];
      pp00_q <= ma[HalfW-1:0] * mb[HalfW-1:0];
      pp01_q <= ma[HalfW-1:0] * mb[rsp_pkg::WordW-1:HalfW];
      pp10_q <= ma[rsp_pkg::WordW-1:HalfW] * mb[HalfW-1:0];
      pp11_q <= ma[rsp_pkg::WordW-1:HalfW] * mb[rsp_pkg::WordW-1:HalfW];
    end
  end

  // full product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg2_q <= neg1_q;
      sum_q  <= {{rsp_pkg::WordW{1'b0}}, pp00_q}
              + {{HalfW{1'b0}}, pp01_q, {HalfW{1'b0}}}
              + {{HalfW{1'b0}}, pp10_q, {HalfW{1'b0}}}
              + {pp11_q, {rsp_pkg::WordW{1'b0}}};
    end
  end

  // scale and clamp
  assign m   = sum_q[TopW-1:rsp_pkg::FracW];
  assign big = (|sum_q[ProdW-1:TopW]) | m[rsp_pkg::WordW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg2_q) begin
        p_q <= big ? rsp_pkg::WordMin : rsp_pkg::word_t'(~m + 1'b1);
      end else begin
        p_q <= big ? rsp_pkg::WordMax : rsp_pkg::word_t'(m);
      end
    end
  end

  assign p_o = p_q;

endmodule

### rtl/core/rsp_dot3.sv
// ============================================================================
// rsp_dot3: pipelined saturating three-term dot product
// Three multiplies in parallel, then two saturating adds in successive
// stages, in the same order as the scalar definition.
// ============================================================================
module rsp_dot3 (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  rsp_pkg::word_t [2:0] a_i,
  input  rsp_pkg::word_t [2:0] b_i,
  output rsp_pkg::word_t       dot_o
);

  rsp_pkg::word_t [2:0] prod;
  rsp_pkg::word_t       s01_q, p2_q, dot_q;

  for (genvar i = 0; i < 3; i++) begin : g_mul
    rsp_fmul u_mul (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (a_i[i]),
      .b_i   (b_i[i]),
      .p_o   (prod[i])
    );
  end

  // first pair, then the third term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s01_q <= rsp_pkg::sat_add(prod[0], prod[1]);
      p2_q  <= prod[2];
      dot_q <= rsp_pkg::sat_add(s01_q, p2_q);
    end
  end

  assign dot_o = dot_q;

endmodule

### rtl/core/rsp_div.sv
// ============================================================================
// rsp_div: pipelined restoring divider for Q48.16 quotients
// Gives |num| * 2^16 / |den| truncated, one quotient bit per stage, with a
// sign flag and an overflow flag for quotients of 2^QB or more.
// ============================================================================
module rsp_div #(
  parameter int unsigned QB = rsp_pkg::TQBits
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  rsp_pkg::word_t num_i,
  input  rsp_pkg::word_t den_i,
  output logic           neg_o,
  output logic           ovf_o,
  output logic [QB-1:0]  q_o
);

  localparam int unsigned W  = rsp_pkg::WordW;
  localparam int unsigned XW = W + rsp_pkg::FracW;

  logic [W-1:0]  mn, md;
  logic [XW-1:0] x, xs;
  logic          ovf;

  logic [W-1:0]  r_q   [QB+1];
  logic [XW-1:0] x_q   [QB+1];
  logic [W-1:0]  md_q  [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic          neg_q [QB+1];
  logic          ovf_q [QB+1];

  // set-up: magnitudes, leading partial remainder, overflow check
  assign mn  = rsp_pkg::mag(num_i);
  assign md  = rsp_pkg::mag(den_i);
  assign x   = {mn, {rsp_pkg::FracW{1'b0}}};
  assign xs  = x >> QB;
  assign ovf = xs >= {{rsp_pkg::FracW{1'b0}}, md};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= ovf ? '0 : xs[W-1:0];
      x_q[0]   <= x;
      md_q[0]  <= md;
      q_q[0]   <= '0;
      neg_q[0] <= num_i[W-1] ^ den_i[W-1];
      ovf_q[0] <= ovf;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int unsigned B = QB - j;
    logic [W:0]    r2;
    logic          ge;
    logic [W:0]    diff;
    logic [QB-1:0] qn;

    assign r2   = {r_q[j-1], x_q[j-1][B]};
    assign ge   = r2 >= {1'b0, md_q[j-1]};
    assign diff = r2 - {1'b0, md_q[j-1]};

    always_comb begin
      qn    = q_q[j-1];
      qn[B] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= ge ? diff[W-1:0] : r2[W-1:0];
        x_q[j]   <= x_q[j-1];
        md_q[j]  <= md_q[j-1];
        q_q[j]   <= qn;
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign neg_o = neg_q[QB];
  assign ovf_o = ovf_q[QB];
  assign q_o   = q_q[QB];

endmodule

### test/rsp_checker.sv
// ----------------------------------------------------------------------------
// rsp_checker: result predictor and comparator for the ray to segment test
// Watches the config, input and output channels, works out the hit flag and
// ray parameter for every accepted pair and checks each result word in order.
// ----------------------------------------------------------------------------
module rsp_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [rsp_pkg::RadiusW-1:0] cfg_data_i,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [383:0]                s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [31:0]                 m_axis_tdata,
  output int                          pending_o,
  output int                          errors_o
);

  localparam int unsigned ParamW  = rsp_pkg::ParamW;
  localparam int unsigned RadiusW = rsp_pkg::RadiusW;
  typedef rsp_pkg::word_t word_t;

  // result word: hit in bit 0, ray parameter above it
  typedef struct packed {
    logic [ParamW-1:0]   param;
    logic                hit;
  } pick_t;

  localparam logic [63:0] Max64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] Min64 = 64'h8000_0000_0000_0000;

  logic [RadiusW-1:0] radius_q;
  pick_t              pick_q[$];

  // exact 65-bit result clamped to the word range
  function automatic word_t clamp65(input logic signed [64:0] x);
    if (x > $signed({1'b0, Max64})) return word_t'(Max64);
    if (x < $signed({1'b1, Min64})) return word_t'(Min64);
    return word_t'(x[63:0]);
  endfunction

  function automatic word_t q_add(input word_t a, input word_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    return clamp65(s);
  endfunction

  function automatic word_t q_sub(input word_t a, input word_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    return clamp65(s);
  endfunction

  function automatic logic [63:0] q_abs(input word_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Q48.16 product, truncated toward zero, saturating
  function automatic word_t q_mul(input word_t a, input word_t b);
    logic          neg;
    logic [127:0]  p;
    logic [63:0]   m;
    neg = a[63] ^ b[63];
    p   = {64'd0, q_abs(a)} * {64'd0, q_abs(b)};
    if (p[127:80] != 0) return neg ? word_t'(Min64) : word_t'(Max64);
    m = p[79:16];
    if (neg) return m[63] ? word_t'(Min64) : word_t'(-m);
    return m[63] ? word_t'(Max64) : word_t'(m);
  endfunction

  // Q48.16 quotient, truncated toward zero, saturating; d nonzero
  function automatic word_t q_div(input word_t n, input word_t d);
    logic        neg;
    logic [79:0] q;
    neg = n[63] ^ d[63];
    q   = {q_abs(n), 16'd0} / {16'd0, q_abs(d)};
    if (q[79:63] != 0) return neg ? word_t'(Min64) : word_t'(Max64);
    return neg ? word_t'(-q[63:0]) : word_t'(q[63:0]);
  endfunction

  function automatic word_t dot(input word_t u[3], input word_t v[3]);
    return q_add(q_add(q_mul(u[0], v[0]), q_mul(u[1], v[1])), q_mul(u[2], v[2]));
  endfunction

  function automatic pick_t pick_test(input logic [383:0] d, input logic [RadiusW-1:0] r);
    word_t org[3], dir[3], st[3], ax[3], w[3], gap[3];
    word_t dd, du, uu, dw, uw, den, t, s, dist2, thr, pr, pa;
    pick_t res;
    for (int i = 0; i < 3; i++) begin
      org[i] = word_t'($signed(d[32*i +: 32]));
      dir[i] = word_t'($signed(d[96 + 32*i +: 32]));
      st[i]  = word_t'($signed(d[192 + 32*i +: 32]));
      ax[i]  = word_t'($signed(d[288 + 32*i +: 32])) - st[i];
      w[i]   = org[i] - st[i];
    end
    dd  = dot(dir, dir);
    du  = dot(dir, ax);
    uu  = dot(ax, ax);
    dw  = dot(dir, w);
    uw  = dot(ax, w);
    den = q_sub(q_mul(dd, uu), q_mul(du, du));
    // parallel or degenerate: project the origin onto the segment
    if (den <= 0) begin
      t = 0;
      s = (uu > 0) ? q_div(uw, uu) : 0;
    end else begin
      t = q_div(q_sub(q_mul(du, uw), q_mul(uu, dw)), den);
      s = q_div(q_sub(q_mul(dd, uw), q_mul(du, dw)), den);
    end
    if (t < 0) t = 0;
    if (s < 0) s = 0;
    else if (s > 65536) s = 65536;
    for (int i = 0; i < 3; i++) begin
      pr     = q_add(org[i], q_mul(dir[i], t));
      pa     = q_add(st[i], q_mul(ax[i], s));
      gap[i] = q_sub(pr, pa);
    end
    dist2 = dot(gap, gap);
    thr   = q_mul(word_t'({33'd0, r}), word_t'({33'd0, r}));
    res.hit   = dist2 < thr;
    res.param = !res.hit ? '0 : (t > 64'sh7fff_ffff) ? '1 : t[ParamW-1:0];
    return res;
  endfunction

  // track channels; the radius is to change only while idle, not enforced here
  always @(posedge clk_i or negedge rst_ni) begin
    pick_t exp_w, got_w;
    if (!rst_ni) begin
      radius_q  <= 31'd65536;
      pick_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) radius_q <= cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) pick_q.push_back(pick_test(s_axis_tdata, radius_q));
      if (m_axis_tvalid && m_axis_tready) begin
        got_w = m_axis_tdata;
        if (pick_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          errors_o <= errors_o + 1;
        end else begin
          exp_w = pick_q.pop_front();
          if (got_w.hit !== exp_w.hit || got_w.param !== exp_w.param)
            errors_o <= errors_o + 1;
          if (got_w.hit !== exp_w.hit)
            $error("hit: expected %0d, got %0d", exp_w.hit, got_w.hit);
          if (got_w.param !== exp_w.param)
            $error("ray_param: expected %0d, got %0d", exp_w.param, got_w.param);
        end
      end
      pending_o <= pick_q.size();
    end
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for ray_segment_proximity_test
// Directed corner pairs, then random pairs mostly aimed near the segment,
// over several click radii and idle patterns, with one long output stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int Limit = 300000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [rsp_pkg::RadiusW-1:0] cfg_data_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [383:0]                s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [31:0]                 m_axis_tdata;
  int                          pending, errors;
  int                          cycles = 0;
  int                          tx_idle = 0, rx_idle = 0;
  logic                        hold_off = 1'b0, hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  ray_segment_proximity_test u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  rsp_checker u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .pending_o(pending), .errors_o(errors)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // output ready, random or held off
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= rx_idle);
  end

  // long stall on the output so the pipe fills and back-pressures
  always @(negedge clk_i) begin
    if (hold_req && !hold_off) begin
      hold_off <= 1'b1;
      repeat (400) @(negedge clk_i);
      hold_off <= 1'b0;
    end
  end

  function automatic int srand(input int n);
    return int'($urandom_range(2 * n)) - n;
  endfunction

  function automatic logic [383:0] pack_pair(input int c[12]);
    logic [383:0] d;
    for (int i = 0; i < 12; i++) d[32*i +: 32] = c[i];
    return d;
  endfunction

  // ray aimed at a random point of a random segment, with some miss offset
  function automatic logic [383:0] aimed_pair();
    int         c[12];
    longint     frac, p;
    int         span;
    int         scale;
    span  = 3276800;
    frac  = $urandom_range(65536);
    scale = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      c[6+i] = srand(span);
      c[9+i] = ($urandom_range(9) == 0) ? c[6+i] : srand(span);
      c[i]   = srand(span);
      p      = c[6+i] + ((longint'(c[9+i]) - c[6+i]) * frac) / 65536;
      c[3+i] = int'(p - c[i]) + srand(40000);
      if (scale == 0) c[3+i] = c[3+i] / 4;
      if (scale == 1) c[3+i] = -c[3+i];
    end
    return pack_pair(c);
  endfunction

  function automatic logic [383:0] random_pair();
    int c[12];
    int sel;
    sel = $urandom_range(99);
    for (int i = 0; i < 12; i++)
      c[i] = (sel < 70) ? 0 : (sel < 85) ? srand(3276800) : int'($urandom);
    return (sel < 70) ? aimed_pair() : pack_pair(c);
  endfunction

  task automatic send_word(input logic [383:0] d);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_radius(input logic [rsp_pkg::RadiusW-1:0] r);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (90) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int tx, input int rx);
    tx_idle = tx;
    rx_idle = rx;
    repeat (n) send_word(random_pair());
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    int c[12];
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_radius(31'd131072);

    // directed corners
    c = '{default: 0};
    send_word(pack_pair(c));
    c = '{default: 32'h7fffffff};
    send_word(pack_pair(c));
    c = '{default: 32'h80000000};
    send_word(pack_pair(c));
    for (int i = 0; i < 12; i++) c[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
    send_word(pack_pair(c));
    // parallel ray offset by 1.0
    c = '{0, 65536, 0,  65536, 0, 0,  0, 0, 0,  655360, 0, 0};
    send_word(pack_pair(c));
    // parallel ray offset by 3.0
    c = '{0, 196608, 0,  65536, 0, 0,  0, 0, 0,  655360, 0, 0};
    send_word(pack_pair(c));
    // degenerate segment, point at origin distance 0.5
    c = '{32768, 0, 0,  0, 65536, 0,  0, 0, 0,  0, 0, 0};
    send_word(pack_pair(c));
    // degenerate segment and zero direction
    c = '{0, 0, 0,  0, 0, 0,  65536, 65536, 0,  65536, 65536, 0};
    send_word(pack_pair(c));
    // perpendicular hit at t = 5
    c = '{0, 0, -327680,  0, 0, 65536,  -655360, 0, 0,  655360, 0, 0};
    send_word(pack_pair(c));
    // ray pointing away: t clamped to zero
    c = '{0, 0, -327680,  0, 0, -65536,  -655360, 0, 0,  655360, 0, 0};
    send_word(pack_pair(c));
    // closest point past the segment end
    c = '{1310720, 0, -327680,  0, 0, 65536,  -655360, 0, 0,  655360, 0, 0};
    send_word(pack_pair(c));
    // far origin, slow ray: ray parameter saturates
    c = '{0, 0, -2000000000,  0, 0, 16,  -655360, 0, 0,  655360, 0, 0};
    send_word(pack_pair(c));
    // near miss just outside the radius
    c = '{0, 140000, -327680,  0, 0, 65536,  -655360, 0, 0,  655360, 0, 0};
    send_word(pack_pair(c));
    // large coordinates forcing saturated products
    c = '{32'h7fffffff, 0, 32'h80000000,  32'h7fffffff, 32'h7fffffff, 1,
          32'h80000000, 5, 0,  32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_word(pack_pair(c));
    s_axis_tvalid <= 1'b0;

    // zero radius: never a hit
    write_radius(31'd0);
    c = '{0, 0, -327680,  0, 0, 65536,  -655360, 0, 0,  655360, 0, 0};
    send_word(pack_pair(c));
    random_phase(100, 6, 67);

    write_radius(31'd65536 + 31'($urandom_range(200000)));
    random_phase(500, 6, 67);

    write_radius(31'h7fffffff);
    random_phase(300, 67, 6);

    write_radius(31'($urandom_range(30000)));
    random_phase(300, 67, 6);

    // no idling, with one long output stall while the sender keeps offering
    write_radius(31'd98304);
    tx_idle = 0;
    rx_idle = 0;
    hold_req <= 1'b1;
    repeat (150) send_word(random_pair());
    hold_req <= 1'b0;
    repeat (300) send_word(random_pair());
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
